>>> hw/rtl/pkst_pkg.sv
// Shared types and constants of the port-knock sequence tracker.
// Used by every module of the block; depends on nothing.
package pkst_pkg;

    localparam int unsigned CLIENT_ENTRIES_DEF = 16;
    localparam int unsigned MAX_SEQ_PORTS_DEF  = 5;
    localparam int unsigned SEQ_PORTS          = 5;
    localparam int unsigned CFG_AW             = 5;

    typedef enum logic [2:0]
    {
        REG_SEQ_LENGTH,
        REG_KNOCK_PORT_0,
        REG_KNOCK_PORT_1,
        REG_KNOCK_PORT_2,
        REG_KNOCK_PORT_3,
        REG_KNOCK_PORT_4,
        REG_WINDOW_SECONDS,
        REG_AUTH_GATE_ENABLE
    } reg_idx_t;

    typedef enum logic [1:0]
    {
        REQ_KNOCK,
        REQ_PURGE,
        REQ_RESET,
        REQ_QUERY
    } req_t;

    typedef enum logic [2:0]
    {
        ST_FIRST,
        ST_STEP,
        ST_COMPLETE,
        ST_WRONG,
        ST_TIMEOUT,
        ST_AUTH,
        ST_FULL,
        ST_DONE
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_EXPIRE,
        S_DECIDE,
        S_DONE
    } fsm_t;

    typedef struct packed
    {
        logic [2:0]                  seq_length;
        logic [SEQ_PORTS-1:0][15:0]  knock_port;
        logic [15:0]                 window_seconds;
        logic                        auth_gate_enable;
    } cfg_t;

    typedef struct packed
    {
        logic        valid;
        logic [31:0] address;
        logic [2:0]  step;
        logic [31:0] start;
    } tbl_rd_t;

    typedef struct packed
    {
        logic        we;
        logic        set_valid;
        logic        clr_valid;
        logic [31:0] address;
        logic [2:0]  step;
        logic [31:0] start;
    } tbl_wr_t;

endpackage

>>> hw/rtl/pkst_cfg.sv
// Configuration register file of the port-knock tracker behind an APB-style port.
// Depends on pkst_pkg for the register indexes and the configuration struct.
module pkst_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pkst_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output pkst_pkg::cfg_t                cfg
);
    import pkst_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_SEQ_LENGTH:       cfg_next.seq_length       = pwdata[2:0];
                REG_KNOCK_PORT_0:     cfg_next.knock_port[0]    = pwdata[15:0];
                REG_KNOCK_PORT_1:     cfg_next.knock_port[1]    = pwdata[15:0];
                REG_KNOCK_PORT_2:     cfg_next.knock_port[2]    = pwdata[15:0];
                REG_KNOCK_PORT_3:     cfg_next.knock_port[3]    = pwdata[15:0];
                REG_KNOCK_PORT_4:     cfg_next.knock_port[4]    = pwdata[15:0];
                REG_WINDOW_SECONDS:   cfg_next.window_seconds   = pwdata[15:0];
                REG_AUTH_GATE_ENABLE: cfg_next.auth_gate_enable = pwdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SEQ_LENGTH:       prdata = {29'd0, cfg_reg.seq_length};
            REG_KNOCK_PORT_0:     prdata = {16'd0, cfg_reg.knock_port[0]};
            REG_KNOCK_PORT_1:     prdata = {16'd0, cfg_reg.knock_port[1]};
            REG_KNOCK_PORT_2:     prdata = {16'd0, cfg_reg.knock_port[2]};
            REG_KNOCK_PORT_3:     prdata = {16'd0, cfg_reg.knock_port[3]};
            REG_KNOCK_PORT_4:     prdata = {16'd0, cfg_reg.knock_port[4]};
            REG_WINDOW_SECONDS:   prdata = {16'd0, cfg_reg.window_seconds};
            REG_AUTH_GATE_ENABLE: prdata = {31'd0, cfg_reg.auth_gate_enable};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seq_length       <= 3'd3;
            cfg_reg.knock_port[0]    <= 16'd7000;
            cfg_reg.knock_port[1]    <= 16'd8000;
            cfg_reg.knock_port[2]    <= 16'd9000;
            cfg_reg.knock_port[3]    <= 16'd0;
            cfg_reg.knock_port[4]    <= 16'd0;
            cfg_reg.window_seconds   <= 16'd30;
            cfg_reg.auth_gate_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/pkst_table.sv
// Client table of the port-knock tracker: entry memory with one registered read
// port and one write port, per-entry valid flags and the count of valid entries.
// Depends on pkst_pkg for the read and write structs.
module pkst_table #(
    parameter int unsigned CLIENT_ENTRIES = pkst_pkg::CLIENT_ENTRIES_DEF,
    localparam int unsigned IW = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1,
    localparam int unsigned CW = $clog2(CLIENT_ENTRIES + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IW-1:0]       rd_idx,
    output pkst_pkg::tbl_rd_t   rd,
    input  logic [IW-1:0]       wr_idx,
    input  pkst_pkg::tbl_wr_t   wr,
    output logic [CW-1:0]       count
);
    import pkst_pkg::*;

    logic [31:0]               entry_address_reg [CLIENT_ENTRIES];
    logic [2:0]                entry_step_reg    [CLIENT_ENTRIES];
    logic [31:0]               entry_start_reg   [CLIENT_ENTRIES];
    logic [CLIENT_ENTRIES-1:0] valid_reg;
    logic [CLIENT_ENTRIES-1:0] valid_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      rd_valid_reg;
    logic [31:0]               rd_address_reg;
    logic [2:0]                rd_step_reg;
    logic [31:0]               rd_start_reg;

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (wr.set_valid)
        begin
            valid_next[wr_idx] = 1'b1;
            count_next         = count_reg + CW'(1);
        end
        else if (wr.clr_valid)
        begin
            valid_next[wr_idx] = 1'b0;
            count_next         = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            entry_address_reg[wr_idx] <= wr.address;
            entry_step_reg[wr_idx]    <= wr.step;
            entry_start_reg[wr_idx]   <= wr.start;
        end
        rd_address_reg <= entry_address_reg[rd_idx];
        rd_step_reg    <= entry_step_reg[rd_idx];
        rd_start_reg   <= entry_start_reg[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    assign rd.valid   = rd_valid_reg;
    assign rd.address = rd_address_reg;
    assign rd.step    = rd_step_reg;
    assign rd.start   = rd_start_reg;
    assign count      = count_reg;

endmodule

>>> hw/rtl/pkst_ctrl.sv
// Sequencer of the port-knock tracker: scans the client table one entry per cycle,
// runs the shared elapsed-time comparator and decides each request's outcome.
// Depends on pkst_pkg; drives pkst_table through its read and write structs.
module pkst_ctrl #(
    parameter int unsigned CLIENT_ENTRIES = pkst_pkg::CLIENT_ENTRIES_DEF,
    parameter int unsigned MAX_SEQ_PORTS  = pkst_pkg::MAX_SEQ_PORTS_DEF,
    localparam int unsigned IW = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1,
    localparam int unsigned CW = $clog2(CLIENT_ENTRIES + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  pkst_pkg::cfg_t      cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pkst_pkg::req_t      req_type,
    input  logic [31:0]         source_ip,
    input  logic [15:0]         dest_port,
    input  logic [31:0]         now_seconds,
    input  logic                auth_ok,
    output logic                m_tvalid,
    input  logic                m_tready,
    output pkst_pkg::status_t   status,
    output logic                access_granted,
    output logic [4:0]          purged_count,
    output logic [4:0]          client_count,
    output logic [IW-1:0]       rd_idx,
    input  pkst_pkg::tbl_rd_t   rd,
    output logic [IW-1:0]       wr_idx,
    output pkst_pkg::tbl_wr_t   wr,
    input  logic [CW-1:0]       count
);
    import pkst_pkg::*;

    localparam logic [2:0]    MAX_LEN = 3'(MAX_SEQ_PORTS);
    localparam logic [CW-1:0] LAST    = CW'(CLIENT_ENTRIES);

    function automatic logic [15:0] port_at(input cfg_t c, input logic [2:0] idx);
        logic [15:0] p;
        case (idx)
            3'd0:    p = c.knock_port[0];
            3'd1:    p = c.knock_port[1];
            3'd2:    p = c.knock_port[2];
            3'd3:    p = c.knock_port[3];
            default: p = c.knock_port[4];
        endcase
        return p;
    endfunction

    fsm_t          state_reg, state_next;
    req_t          req_reg, req_next;
    logic [31:0]   ip_reg, ip_next;
    logic [15:0]   port_reg, port_next;
    logic [31:0]   now_reg, now_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [IW-1:0] chk_idx_reg, chk_idx_next;
    logic          found_reg, found_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [2:0]    hit_step_reg, hit_step_next;
    logic [31:0]   hit_start_reg, hit_start_next;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          exp_reg, exp_next;
    status_t       status_reg, status_next;
    logic          granted_reg, granted_next;
    logic [CW-1:0] purged_reg, purged_next;
    logic          out_vld_reg, out_vld_next;
    status_t       out_status_reg, out_status_next;
    logic          out_granted_reg, out_granted_next;
    logic [4:0]    out_purged_reg, out_purged_next;
    logic [4:0]    out_count_reg, out_count_next;

    logic [2:0]    len;
    logic [31:0]   unit_start;
    logic [31:0]   unit_elapsed;
    logic          unit_late;
    logic [2:0]    cur_step;
    logic [15:0]   port0;

    assign len          = (cfg.seq_length > MAX_LEN) ? MAX_LEN : cfg.seq_length;
    assign port0        = cfg.knock_port[0];
    assign unit_start   = (state_reg == S_SCAN) ? rd.start : hit_start_reg;
    assign unit_elapsed = now_reg - unit_start;
    assign unit_late    = unit_elapsed > {16'd0, cfg.window_seconds};
    assign cur_step     = exp_reg ? 3'd0 : hit_step_reg;
    assign rd_idx       = cnt_reg[IW-1:0];

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        ip_next          = ip_reg;
        port_next        = port_reg;
        now_next         = now_reg;
        cnt_next         = cnt_reg;
        chk_vld_next     = 1'b0;
        chk_idx_next     = chk_idx_reg;
        found_next       = found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_step_next    = hit_step_reg;
        hit_start_next   = hit_start_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        exp_next         = exp_reg;
        status_next      = status_reg;
        granted_next     = granted_reg;
        purged_next      = purged_reg;
        out_vld_next     = out_vld_reg & ~m_tready;
        out_status_next  = out_status_reg;
        out_granted_next = out_granted_reg;
        out_purged_next  = out_purged_reg;
        out_count_next   = out_count_reg;
        s_tready         = (state_reg == S_IDLE);
        wr_idx           = hit_idx_reg;
        wr.we            = 1'b0;
        wr.set_valid     = 1'b0;
        wr.clr_valid     = 1'b0;
        wr.address       = ip_reg;
        wr.step          = 3'd0;
        wr.start         = hit_start_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next        = req_type;
                    ip_next         = source_ip;
                    port_next       = dest_port;
                    now_next        = now_seconds;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    exp_next        = 1'b0;
                    purged_next     = '0;
                    granted_next    = 1'b0;
                    status_next     = ST_DONE;
                    case (req_type)
                        REQ_KNOCK:
                        begin
                            if (cfg.auth_gate_enable && !auth_ok)
                            begin
                                status_next = ST_AUTH;
                                state_next  = S_DONE;
                            end
                            else if (len == 3'd0)
                            begin
                                status_next = ST_WRONG;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        REQ_PURGE: state_next = S_SCAN;
                        REQ_RESET: state_next = S_SCAN;
                        default:   state_next = S_DONE;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (cnt_reg != LAST)
                begin
                    cnt_next     = cnt_reg + CW'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = cnt_reg[IW-1:0];
                end
                if (chk_vld_reg)
                begin
                    if (req_reg == REQ_PURGE)
                    begin
                        if (rd.valid && rd.step != 3'd0 && unit_late)
                        begin
                            wr_idx       = chk_idx_reg;
                            wr.clr_valid = 1'b1;
                            purged_next  = purged_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (rd.valid && rd.address == ip_reg && !found_reg)
                        begin
                            found_next     = 1'b1;
                            hit_idx_next   = chk_idx_reg;
                            hit_step_next  = rd.step;
                            hit_start_next = rd.start;
                        end
                        if (!rd.valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                    end
                end
                if (cnt_reg == LAST)
                begin
                    case (req_reg)
                        REQ_KNOCK: state_next = S_EXPIRE;
                        REQ_RESET: state_next = S_DECIDE;
                        default:   state_next = S_DONE;
                    endcase
                end
            end

            S_EXPIRE:
            begin
                exp_next   = found_reg && (hit_step_reg != 3'd0) && unit_late;
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                state_next = S_DONE;
                if (req_reg == REQ_RESET)
                begin
                    wr.we = found_reg;
                end
                else if (!found_reg)
                begin
                    if (port_reg != port0)
                    begin
                        status_next = ST_WRONG;
                    end
                    else if (len == 3'd1)
                    begin
                        status_next  = ST_COMPLETE;
                        granted_next = 1'b1;
                    end
                    else if (!free_found_reg)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_idx       = free_idx_reg;
                        wr.we        = 1'b1;
                        wr.set_valid = 1'b1;
                        wr.step      = 3'd1;
                        wr.start     = now_reg;
                        status_next  = ST_FIRST;
                    end
                end
                else if (exp_reg && port_reg != port0)
                begin
                    wr.we       = 1'b1;
                    status_next = ST_TIMEOUT;
                end
                else if (cur_step >= len || port_reg != port_at(cfg, cur_step))
                begin
                    wr.we       = 1'b1;
                    status_next = ST_WRONG;
                end
                else if (cur_step == 3'd0)
                begin
                    if (len == 3'd1)
                    begin
                        wr.clr_valid = 1'b1;
                        status_next  = ST_COMPLETE;
                        granted_next = 1'b1;
                    end
                    else
                    begin
                        wr.we       = 1'b1;
                        wr.step     = 3'd1;
                        wr.start    = now_reg;
                        status_next = ST_FIRST;
                    end
                end
                else if (cur_step + 3'd1 >= len)
                begin
                    wr.clr_valid = 1'b1;
                    status_next  = ST_COMPLETE;
                    granted_next = 1'b1;
                end
                else
                begin
                    wr.we       = 1'b1;
                    wr.step     = cur_step + 3'd1;
                    status_next = ST_STEP;
                end
            end

            S_DONE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next     = 1'b1;
                    out_status_next  = status_reg;
                    out_granted_next = granted_reg;
                    out_purged_next  = 5'(purged_reg);
                    out_count_next   = 5'(count);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        ip_reg          <= ip_next;
        port_reg        <= port_next;
        now_reg         <= now_next;
        cnt_reg         <= cnt_next;
        chk_idx_reg     <= chk_idx_next;
        found_reg       <= found_next;
        hit_idx_reg     <= hit_idx_next;
        hit_step_reg    <= hit_step_next;
        hit_start_reg   <= hit_start_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        exp_reg         <= exp_next;
        status_reg      <= status_next;
        granted_reg     <= granted_next;
        purged_reg      <= purged_next;
        out_status_reg  <= out_status_next;
        out_granted_reg <= out_granted_next;
        out_purged_reg  <= out_purged_next;
        out_count_reg   <= out_count_next;
    end

    assign m_tvalid       = out_vld_reg;
    assign status         = out_status_reg;
    assign access_granted = out_granted_reg;
    assign purged_count   = out_purged_reg;
    assign client_count   = out_count_reg;

    // Access is granted exactly on a completed sequence.
    a_grant_complete: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_granted_reg == (out_status_reg == ST_COMPLETE)))
        else $error("access_granted disagrees with status");

    // Only a purge, which answers done, reports freed entries.
    a_purge_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_status_reg != ST_DONE) |-> (out_purged_reg == 5'd0))
        else $error("purged count on a non-purge result");

    // A slot is never taken and freed in the same cycle.
    a_set_clr: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr.set_valid && wr.clr_valid))
        else $error("table entry set and cleared together");

    // Entry data is written only once the scan has finished.
    a_write_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.we || wr.set_valid) |-> (state_reg == S_DECIDE))
        else $error("table written outside the decide step");

endmodule

>>> hw/rtl/port_knock_sequence_tracker.sv
// Port-knock sequence tracker. Each word on the input stream is a knock, a purge of
// expired clients, a reset of one client or a count query, and gives exactly one result
// word. Knocks, purges and resets walk the client table one entry per cycle through its
// single read port and one shared elapsed-time comparator; after the scan a knock passes
// through the expire and decide steps, a reset through the decide step, and a purge
// finishes directly. A query, or a knock rejected by the authentication gate or an
// empty sequence, skips the scan. s_tready is high only between requests, so the block
// takes no new request before the last one is done, and a finished result waits in
// the output register. The table is usable directly after reset.
module port_knock_sequence_tracker #(
    parameter int unsigned CLIENT_ENTRIES = pkst_pkg::CLIENT_ENTRIES_DEF,
    parameter int unsigned MAX_SEQ_PORTS  = pkst_pkg::MAX_SEQ_PORTS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // source_ip[31:0], dest_port[47:32], now_seconds[79:48], auth_ok[80], zero fill.
    input  logic [87:0]                   s_tdata,
    // req_type[1:0].
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[2:0], access_granted[3], purged_count[8:4], client_count[13:9], zero fill.
    output logic [15:0]                   m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pkst_pkg::CFG_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import pkst_pkg::*;

    localparam int unsigned IW = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(CLIENT_ENTRIES + 1);

    cfg_t          cfg;
    tbl_rd_t       tbl_rd;
    tbl_wr_t       tbl_wr;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] wr_idx;
    logic [CW-1:0] count;
    status_t       status;
    logic          access_granted;
    logic [4:0]    purged_count;
    logic [4:0]    client_count;

    pkst_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pkst_table #(
        .CLIENT_ENTRIES (CLIENT_ENTRIES)
    ) u_table
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (rd_idx),
        .rd     (tbl_rd),
        .wr_idx (wr_idx),
        .wr     (tbl_wr),
        .count  (count)
    );

    pkst_ctrl #(
        .CLIENT_ENTRIES (CLIENT_ENTRIES),
        .MAX_SEQ_PORTS  (MAX_SEQ_PORTS)
    ) u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .req_type       (req_t'(s_tuser)),
        .source_ip      (s_tdata[31:0]),
        .dest_port      (s_tdata[47:32]),
        .now_seconds    (s_tdata[79:48]),
        .auth_ok        (s_tdata[80]),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .status         (status),
        .access_granted (access_granted),
        .purged_count   (purged_count),
        .client_count   (client_count),
        .rd_idx         (rd_idx),
        .rd             (tbl_rd),
        .wr_idx         (wr_idx),
        .wr             (tbl_wr),
        .count          (count)
    );

    assign m_tdata = {2'b00, client_count, purged_count, access_granted, status};

endmodule
